### design/stprs_pkg.sv
// Shared types and constants for the point-set / range-sum segment tree.
// Used by the top level, stprs_seq, stprs_acc, the checkers and the testbench; no dependencies.
package stprs_pkg;

  // Field widths of the stream beats
  localparam int unsigned OP_W        = 2;
  localparam int unsigned POS_W       = 11;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned SUM_W       = 42;
  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 48;

  // Default number of leaves
  localparam int unsigned LEAVES_DEF = 1024;

  // Operation codes carried in the input tuser
  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_SET   = 2'd1,
    OP_QUERY = 2'd2
  } op_e;

  // Commands for the shared accumulator/adder
  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_CLR,
    ACC_LOAD,
    ACC_ADD
  } acc_op_e;

  typedef struct packed {
    acc_op_e                op;
    logic [SUM_W-1:0]       load_val;
  } acc_ctrl_t;

endpackage

### design/segment_tree_point_set_range_sum.sv
// Top level of the point-set / range-sum segment tree.
// Instantiates stprs_seq, stprs_ram and stprs_acc; uses stprs_pkg.
//
//  Port group  Dir  Payload (lowest bit first)
//  s_axis_*    in   tuser: operation[1:0]
//                   tdata: position[10:0] leaf_value[42:11] range_low[53:43]
//                          range_high[64:54], zero pad [71:65]
//  m_axis_*    out  tdata: range_sum[41:0], zero pad [47:42]
//
//  Operation: one item at a time through a single-port node memory and one adder.
//  Set: per tree level a sibling read, then a parent write, up to the root.
//  Query: per level a left-bound step and a right-bound step; an empty range ends at once.
//  Clear: one node per cycle, every node written with zero.
//  After reset the same clearing pass runs with s_axis_tready low.
//  A finished result sits in the output register, so the next beat is taken while it waits.
module segment_tree_point_set_range_sum #(
  parameter int unsigned LEAVES = stprs_pkg::LEAVES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [stprs_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,  // position, leaf_value, range_low, range_high
  input  logic [stprs_pkg::IN_TUSER_W-1:0]  s_axis_tuser_i,  // operation
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [stprs_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o   // range_sum
);
  import stprs_pkg::*;

  localparam int unsigned NW    = $clog2(2 * LEAVES);
  localparam int unsigned DEPTH = 2 * LEAVES;

  logic              start, idle, done, out_free;
  logic [SUM_W-1:0]  result;
  logic              ram_we, ram_re;
  logic [NW-1:0]     ram_addr;
  logic [SUM_W-1:0]  ram_wdata, ram_rdata;
  acc_ctrl_t         acc_ctrl;
  logic [SUM_W-1:0]  acc, sum;

  logic              out_valid_q;
  logic [SUM_W-1:0]  out_data_q;

  assign s_axis_tready_o = idle;
  assign start           = s_axis_tvalid_i && idle;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  stprs_seq #(
    .LEAVES (LEAVES),
    .NW     (NW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .op_i        (op_e'(s_axis_tuser_i[OP_W-1:0])),
    .pos_i       (s_axis_tdata_i[POS_W-1:0]),
    .val_i       (s_axis_tdata_i[POS_W +: VAL_W]),
    .lo_i        (s_axis_tdata_i[POS_W+VAL_W +: POS_W]),
    .hi_i        (s_axis_tdata_i[2*POS_W+VAL_W +: POS_W]),
    .idle_o      (idle),
    .out_free_i  (out_free),
    .done_o      (done),
    .result_o    (result),
    .ram_we_o    (ram_we),
    .ram_re_o    (ram_re),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .acc_ctrl_o  (acc_ctrl),
    .acc_i       (acc),
    .sum_i       (sum)
  );

  stprs_ram #(
    .DEPTH (DEPTH),
    .AW    (NW),
    .DW    (SUM_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  stprs_acc u_acc (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (acc_ctrl),
    .operand_i (ram_rdata),
    .acc_o     (acc),
    .sum_o     (sum)
  );

  // output register: loads when the sequencer finishes and the slot is free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done && out_free) begin
      out_data_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_TDATA_W-SUM_W){1'b0}}, out_data_q};

endmodule

### design/stprs_ram.sv
// Single-port node-sum memory with registered read data.
// Depends on nothing; sized by the parameters handed down from the top level.
module stprs_ram #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned AW    = 11,
  parameter int unsigned DW    = 42
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic          re_i,
  input  logic [AW-1:0] addr_i,
  input  logic [DW-1:0] wdata_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  // one access per cycle: write, or read into the output register
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/stprs_acc.sv
// Shared 42-bit adder with its accumulator register.
// Serves as running sum for queries and as path sum for leaf updates; uses stprs_pkg.
module stprs_acc (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  stprs_pkg::acc_ctrl_t        ctrl_i,
  input  logic [stprs_pkg::SUM_W-1:0] operand_i,
  output logic [stprs_pkg::SUM_W-1:0] acc_o,
  output logic [stprs_pkg::SUM_W-1:0] sum_o
);
  import stprs_pkg::*;

  logic [SUM_W-1:0] acc_q, acc_d;

  // the one adder of the block; wraps modulo 2^42
  assign sum_o = acc_q + operand_i;

  always_comb begin
    case (ctrl_i.op)
      ACC_HOLD: acc_d = acc_q;
      ACC_CLR:  acc_d = '0;
      ACC_LOAD: acc_d = ctrl_i.load_val;
      ACC_ADD:  acc_d = sum_o;
      default:  acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

### design/stprs_seq.sv
// Sequencer: clearing sweep, leaf-to-root update and bottom-up range walk.
// Drives stprs_ram and stprs_acc; uses stprs_pkg.
module stprs_seq #(
  parameter int unsigned LEAVES = stprs_pkg::LEAVES_DEF,
  parameter int unsigned NW     = $clog2(2 * LEAVES)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // item in
  input  logic                        start_i,
  input  stprs_pkg::op_e              op_i,
  input  logic [stprs_pkg::POS_W-1:0] pos_i,
  input  logic [stprs_pkg::VAL_W-1:0] val_i,
  input  logic [stprs_pkg::POS_W-1:0] lo_i,
  input  logic [stprs_pkg::POS_W-1:0] hi_i,
  output logic                        idle_o,
  // result out
  input  logic                        out_free_i,
  output logic                        done_o,
  output logic [stprs_pkg::SUM_W-1:0] result_o,
  // node memory
  output logic                        ram_we_o,
  output logic                        ram_re_o,
  output logic [NW-1:0]               ram_addr_o,
  output logic [stprs_pkg::SUM_W-1:0] ram_wdata_o,
  // shared adder
  output stprs_pkg::acc_ctrl_t        acc_ctrl_o,
  input  logic [stprs_pkg::SUM_W-1:0] acc_i,
  input  logic [stprs_pkg::SUM_W-1:0] sum_i
);
  import stprs_pkg::*;

  // walk pointers need one bit more than a node index (right bound reaches 2*LEAVES)
  localparam int unsigned AW = NW + 1;
  localparam int unsigned CW = ((NW > POS_W) ? NW : POS_W) + 1;
  localparam logic [CW-1:0] LEAVES_C  = CW'(LEAVES);
  localparam logic [NW-1:0] LAST_NODE = NW'(2 * LEAVES - 1);
  localparam logic [NW-1:0] ROOT_NODE = NW'(1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLR,
    S_SRD,
    S_SWR,
    S_QTEST,
    S_QLACC,
    S_QR,
    S_QRACC,
    S_DONE
  } state_e;

  state_e        state_q, state_d;
  logic [NW-1:0] k_q, k_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] l_q, l_d;
  logic [AW-1:0] r_q, r_d;
  op_e           op_q, op_d;
  logic          item_q, item_d;

  logic [CW-1:0] pos_x, lo_x, hi_x, lo_c, hi_c;
  logic [CW-1:0] leaf_x, l_init, r_init;
  logic          pos_ok, range_ok;
  logic [NW-1:0] parent;
  logic [AW-1:0] r_m1;

  // operand decode at the input beat
  assign pos_x    = {{(CW-POS_W){1'b0}}, pos_i};
  assign lo_x     = {{(CW-POS_W){1'b0}}, lo_i};
  assign hi_x     = {{(CW-POS_W){1'b0}}, hi_i};
  assign lo_c     = (lo_x == '0) ? CW'(1) : lo_x;
  assign hi_c     = (hi_x > LEAVES_C) ? LEAVES_C : hi_x;
  assign pos_ok   = (pos_x != '0) && (pos_x <= LEAVES_C);
  assign range_ok = (lo_c <= hi_c);
  assign leaf_x   = LEAVES_C + pos_x - CW'(1);
  assign l_init   = LEAVES_C + lo_c - CW'(1);
  assign r_init   = LEAVES_C + hi_c;

  assign parent = {1'b0, k_q[NW-1:1]};
  assign r_m1   = r_q - AW'(1);

  // next state and datapath control
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    cnt_d   = cnt_q;
    l_d     = l_q;
    r_d     = r_q;
    op_d    = op_q;
    item_d  = item_q;
    ram_we_o    = 1'b0;
    ram_re_o    = 1'b0;
    ram_addr_o  = '0;
    ram_wdata_o = '0;
    acc_ctrl_o.op       = ACC_HOLD;
    acc_ctrl_o.load_val = '0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          item_d = 1'b1;
          op_d   = op_i;
          case (op_i)
            OP_CLEAR: begin
              cnt_d   = '0;
              state_d = S_CLR;
            end
            OP_SET: begin
              if (pos_ok) begin
                ram_we_o            = 1'b1;
                ram_addr_o          = leaf_x[NW-1:0];
                ram_wdata_o         = {{(SUM_W-VAL_W){1'b0}}, val_i};
                acc_ctrl_o.op       = ACC_LOAD;
                acc_ctrl_o.load_val = {{(SUM_W-VAL_W){1'b0}}, val_i};
                k_d                 = leaf_x[NW-1:0];
                state_d             = S_SRD;
              end else begin
                state_d = S_DONE;
              end
            end
            OP_QUERY: begin
              acc_ctrl_o.op = ACC_CLR;
              l_d           = l_init[AW-1:0];
              r_d           = r_init[AW-1:0];
              state_d       = range_ok ? S_QTEST : S_DONE;
            end
            default: state_d = S_DONE;
          endcase
        end
      end

      // zero one node a cycle
      S_CLR: begin
        ram_we_o   = 1'b1;
        ram_addr_o = cnt_q;
        cnt_d      = cnt_q + NW'(1);
        if (cnt_q == LAST_NODE) begin
          state_d = item_q ? S_DONE : S_IDLE;
        end
      end

      // update: fetch the sibling, then write the parent
      S_SRD: begin
        ram_re_o   = 1'b1;
        ram_addr_o = {k_q[NW-1:1], ~k_q[0]};
        state_d    = S_SWR;
      end

      S_SWR: begin
        acc_ctrl_o.op = ACC_ADD;
        ram_we_o      = 1'b1;
        ram_addr_o    = parent;
        ram_wdata_o   = sum_i;
        k_d           = parent;
        state_d       = (parent == ROOT_NODE) ? S_DONE : S_SRD;
      end

      // query: left bound of the level
      S_QTEST: begin
        if (l_q >= r_q) begin
          state_d = S_DONE;
        end else if (l_q[0]) begin
          ram_re_o   = 1'b1;
          ram_addr_o = l_q[NW-1:0];
          state_d    = S_QLACC;
        end else begin
          state_d = S_QR;
        end
      end

      S_QLACC: begin
        acc_ctrl_o.op = ACC_ADD;
        l_d           = l_q + AW'(1);
        state_d       = S_QR;
      end

      // query: right bound, then climb a level
      S_QR: begin
        if (r_q[0]) begin
          ram_re_o   = 1'b1;
          ram_addr_o = r_m1[NW-1:0];
          r_d        = r_m1;
          state_d    = S_QRACC;
        end else begin
          l_d     = l_q >> 1;
          r_d     = r_q >> 1;
          state_d = S_QTEST;
        end
      end

      S_QRACC: begin
        acc_ctrl_o.op = ACC_ADD;
        l_d           = l_q >> 1;
        r_d           = r_q >> 1;
        state_d       = S_QTEST;
      end

      S_DONE: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // state and registers; reset starts the clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      cnt_q   <= '0;
      item_q  <= 1'b0;
      op_q    <= OP_CLEAR;
      k_q     <= '0;
      l_q     <= '0;
      r_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      item_q  <= item_d;
      op_q    <= op_d;
      k_q     <= k_d;
      l_q     <= l_d;
      r_q     <= r_d;
    end
  end

  assign idle_o   = (state_q == S_IDLE);
  assign done_o   = (state_q == S_DONE);
  assign result_o = (op_q == OP_QUERY) ? acc_i : '0;

endmodule

### design/stprs_checker.sv
// Port-level checker for the segment tree block, bound to the top level.
// Uses stprs_pkg for beat widths.
module stprs_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid_i,
  input logic                              s_axis_tready_i,
  input logic                              m_axis_tvalid_i,
  input logic                              m_axis_tready_i,
  input logic [stprs_pkg::OUT_TDATA_W-1:0] m_axis_tdata_i
);
  import stprs_pkg::*;

  // the block takes one item at a time
  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_i |=> !s_axis_tready_i)
    else $error("input accepted twice in a row");

  // a result only appears after the block has been busy
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_i) |-> $past(!s_axis_tready_i))
    else $error("result appeared without work in progress");

  // the clearing pass after reset keeps the input closed
  a_clear_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !s_axis_tready_i)
    else $error("input open before the node memory is cleared");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=> m_axis_tvalid_i && $stable(m_axis_tdata_i))
    else $error("stalled result changed");

endmodule

bind segment_tree_point_set_range_sum stprs_checker u_stprs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_i (s_axis_tready_o),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o)
);

### verif/stprs_checker.sv
// Checker for the point-set / range-sum segment tree: keeps its own copy of
// the node sums, predicts one range sum per input beat and compares output beats.
// Depends on stprs_pkg.
module stprs_tb_checker #(
  parameter int unsigned LEAVES = stprs_pkg::LEAVES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_tvalid_i,
  input  logic                              s_tready_i,
  input  logic [stprs_pkg::IN_TDATA_W-1:0]  s_tdata_i,   // position, leaf_value, range_low, range_high
  input  logic [stprs_pkg::IN_TUSER_W-1:0]  s_tuser_i,   // operation
  input  logic                              m_tvalid_i,
  input  logic                              m_tready_i,
  input  logic [stprs_pkg::OUT_TDATA_W-1:0] m_tdata_i,   // range_sum
  output int unsigned                       mismatch_cnt_o,
  output int unsigned                       pending_cnt_o
);
  import stprs_pkg::*;

  // Shadow tree: node 1 is the root, leaf p sits at node LEAVES + p - 1
  logic [SUM_W-1:0] node_sum [2*LEAVES];
  // Range sums still owed by the block, oldest first
  logic [SUM_W-1:0] sums_due [$];

  // Write one leaf and refresh the sums on its path to the root
  function automatic void leaf_write(int unsigned pos, logic [VAL_W-1:0] val);
    int unsigned k;
    if (pos < 1 || pos > LEAVES) return;  // off the tree: ignored
    k = LEAVES + pos - 1;
    node_sum[k] = SUM_W'(val);
    k = k >> 1;
    while (k >= 1) begin
      node_sum[k] = node_sum[2*k] + node_sum[2*k+1];
      k = k >> 1;
    end
  endfunction

  // Bottom-up sum over lo..hi, clipped to the tree; empty gives zero
  function automatic logic [SUM_W-1:0] range_total(int unsigned lo, int unsigned hi);
    logic [SUM_W-1:0] acc;
    int unsigned      l;
    int unsigned      r;
    acc = '0;
    if (lo < 1) lo = 1;
    if (hi > LEAVES) hi = LEAVES;
    if (lo > hi) return '0;
    l = LEAVES + lo - 1;
    r = LEAVES + hi;
    while (l < r) begin
      if ((l & 1) != 0) begin
        acc = acc + node_sum[l];
        l++;
      end
      if ((r & 1) != 0) begin
        r--;
        acc = acc + node_sum[r];
      end
      l = l >> 1;
      r = r >> 1;
    end
    return acc;
  endfunction

  // Apply one input beat to the shadow tree and return the sum it yields
  function automatic logic [SUM_W-1:0] apply_beat(logic [IN_TUSER_W-1:0] op,
                                                  logic [IN_TDATA_W-1:0] data);
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    logic [POS_W-1:0] lo;
    logic [POS_W-1:0] hi;
    pos = data[POS_W-1:0];
    val = data[POS_W +: VAL_W];
    lo  = data[POS_W+VAL_W +: POS_W];
    hi  = data[2*POS_W+VAL_W +: POS_W];
    case (op)
      OP_CLEAR: begin
        foreach (node_sum[i]) node_sum[i] = '0;
      end
      OP_SET: begin
        leaf_write(pos, val);
      end
      OP_QUERY: begin
        return range_total(lo, hi);
      end
      default: ;  // unused code: no effect
    endcase
    return '0;
  endfunction

  // Outputs are matched before inputs are taken, so a beat accepted at this
  // edge can never pair with a result leaving at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    logic [SUM_W-1:0] due;
    logic [SUM_W-1:0] beat_sum;
    int unsigned      errs;
    errs = 0;
    if (!rst_ni) begin
      foreach (node_sum[i]) node_sum[i] = '0;
      sums_due.delete();
      mismatch_cnt_o <= 0;
      pending_cnt_o  <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (sums_due.size() == 0) begin
          $error("range_sum: beat with nothing expected, got %0d", m_tdata_i[SUM_W-1:0]);
          errs++;
        end else begin
          due = sums_due.pop_front();
          if (m_tdata_i[SUM_W-1:0] !== due) begin
            $error("range_sum: expected %0d, got %0d", due, m_tdata_i[SUM_W-1:0]);
            errs++;
          end
          if (m_tdata_i[OUT_TDATA_W-1:SUM_W] !== '0) begin
            $error("tdata pad: expected 0, got %0h", m_tdata_i[OUT_TDATA_W-1:SUM_W]);
            errs++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        beat_sum = apply_beat(s_tuser_i, s_tdata_i);
        sums_due = {sums_due, beat_sum};
      end
      mismatch_cnt_o <= mismatch_cnt_o + errs;
      pending_cnt_o  <= sums_due.size();
    end
  end

endmodule

### verif/segment_tree_point_set_range_sum_tb.sv
// Testbench top for the segment tree: drives directed and random operations
// with random gaps and output stalls, and gives the verdict.
// Depends on stprs_pkg, stprs_tb_checker and the block itself.
module segment_tree_point_set_range_sum_tb;
  import stprs_pkg::*;

  localparam int unsigned      LEAVES       = LEAVES_DEF;
  localparam int               CLK_PERIOD   = 10;
  localparam int unsigned      DRAIN_CYCLES = 64;
  localparam logic [OP_W-1:0]  OP_RSVD      = 2'd3;  // code the block must ignore
  localparam logic [VAL_W-1:0] VAL_MAX      = '1;
  localparam int unsigned      POS_TOP      = (1 << POS_W) - 1;

  logic                   clk_i    = 1'b0;
  logic                   rst_ni   = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic [IN_TUSER_W-1:0]  s_tuser  = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  int unsigned            mismatch_cnt;
  int unsigned            pending_cnt;

  // Sender idles only when this is clear
  bit                     no_gaps = 1'b0;
  int unsigned            rdy_run = 0;

  always begin
    #(CLK_PERIOD/2) clk_i = 1'b1;
    #(CLK_PERIOD/2) clk_i = 1'b0;
  end

  segment_tree_point_set_range_sum #(
    .LEAVES (LEAVES)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  stprs_tb_checker #(
    .LEAVES (LEAVES)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_tvalid_i     (s_tvalid),
    .s_tready_i     (s_tready),
    .s_tdata_i      (s_tdata),
    .s_tuser_i      (s_tuser),
    .m_tvalid_i     (m_tvalid),
    .m_tready_i     (m_tready),
    .m_tdata_i      (m_tdata),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_cnt_o  (pending_cnt)
  );

  // Output back-pressure: runs of ready and of stall, mostly short
  always @(posedge clk_i) begin
    int unsigned pick;
    if (rdy_run != 0) begin
      rdy_run = rdy_run - 1;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        m_tready <= 1'b1;
        rdy_run = $urandom_range(0, 30);
      end else if (pick < 60) begin
        m_tready <= 1'b1;
        rdy_run = $urandom_range(200, 500);
      end else if (pick < 92) begin
        m_tready <= 1'b0;
        rdy_run = $urandom_range(0, 3);
      end else begin
        m_tready <= 1'b0;
        rdy_run = $urandom_range(20, 80);
      end
    end
  end

  function automatic int unsigned draw_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (no_gaps || pick < 45) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 80);
  endfunction

  // One input beat; valid stays up when no gap follows
  task automatic send_beat(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                           input logic [VAL_W-1:0] val, input logic [POS_W-1:0] lo,
                           input logic [POS_W-1:0] hi);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {{(IN_TDATA_W-2*POS_W-VAL_W-POS_W){1'b0}}, hi, lo, val, pos};
    do @(posedge clk_i); while (!s_tready);
    gap = draw_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic [VAL_W-1:0] pick_value(int unsigned max_pct);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < max_pct) return VAL_MAX;
    if (pick < max_pct + 8) return '0;
    if (pick < max_pct + 20) return VAL_W'($urandom_range(1, 255));
    return $urandom();
  endfunction

  // Query ranges: short, wide, whole tree, inverted, or anything the field holds
  task automatic pick_range(output logic [POS_W-1:0] lo, output logic [POS_W-1:0] hi);
    int unsigned pick;
    int unsigned a;
    int unsigned b;
    pick = $urandom_range(0, 99);
    a = $urandom_range(1, LEAVES);
    b = $urandom_range(1, LEAVES);
    if (pick < 35) begin
      lo = POS_W'(a);
      hi = POS_W'((a + $urandom_range(0, 15) > LEAVES) ? LEAVES : a + $urandom_range(0, 15));
    end else if (pick < 70) begin
      lo = POS_W'((a < b) ? a : b);
      hi = POS_W'((a < b) ? b : a);
    end else if (pick < 80) begin
      lo = POS_W'(1);
      hi = POS_W'(LEAVES);
    end else if (pick < 90) begin
      a  = $urandom_range(2, LEAVES);
      lo = POS_W'(a);
      hi = POS_W'($urandom_range(1, a - 1));
    end else begin
      lo = POS_W'($urandom_range(0, POS_TOP));
      hi = POS_W'($urandom_range(0, POS_TOP));
    end
  endtask

  initial begin
    int unsigned      pick;
    int unsigned      sweep;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] lo;
    logic [POS_W-1:0] hi;
    logic [VAL_W-1:0] val;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, positions off the tree, clipped and empty ranges
    send_beat(OP_QUERY, 0, 0, 1, POS_W'(LEAVES));
    send_beat(OP_SET, 1, VAL_MAX, 0, 0);
    send_beat(OP_SET, POS_W'(LEAVES), VAL_MAX, 0, 0);
    send_beat(OP_SET, 512, 32'h8000_0001, 0, 0);
    send_beat(OP_SET, 0, 32'd123, 0, 0);
    send_beat(OP_SET, POS_W'(LEAVES + 1), 32'd77, 0, 0);
    send_beat(OP_SET, POS_W'(POS_TOP), VAL_MAX, 0, 0);
    send_beat(OP_QUERY, 0, 0, 1, POS_W'(LEAVES));
    send_beat(OP_QUERY, 0, 0, 1, 1);
    send_beat(OP_QUERY, 0, 0, POS_W'(LEAVES), POS_W'(LEAVES));
    send_beat(OP_QUERY, 0, 0, 0, POS_W'(POS_TOP));
    send_beat(OP_QUERY, 0, 0, 600, 3);
    send_beat(OP_QUERY, 0, 0, POS_W'(LEAVES + 1), POS_W'(POS_TOP));
    send_beat(OP_QUERY, 0, 0, 0, 0);
    send_beat(OP_RSVD, POS_W'(POS_TOP), VAL_MAX, POS_W'(POS_TOP), POS_W'(POS_TOP));
    send_beat(OP_QUERY, 0, 0, 2, POS_W'(LEAVES - 1));
    send_beat(OP_SET, 1, 0, 0, 0);
    send_beat(OP_QUERY, 0, 0, 1, 512);
    send_beat(OP_CLEAR, POS_W'(POS_TOP), VAL_MAX, POS_W'(POS_TOP), POS_W'(POS_TOP));
    send_beat(OP_QUERY, 0, 0, 1, POS_W'(LEAVES));
    send_beat(OP_SET, 513, VAL_MAX, 0, 0);
    send_beat(OP_QUERY, 0, 0, 512, 513);
    send_beat(OP_QUERY, 0, 0, 513, POS_W'(POS_TOP));

    // Random, first part: every operation, clears now and then, noisy fields
    for (int i = 0; i < 500; i++) begin
      if (i % 100 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      pos  = POS_W'($urandom());
      val  = $urandom();
      lo   = POS_W'($urandom());
      hi   = POS_W'($urandom());
      if (pick < 3) begin
        send_beat(OP_CLEAR, pos, val, lo, hi);
      end else if (pick < 48) begin
        if ($urandom_range(0, 9) != 0) pos = POS_W'($urandom_range(1, LEAVES));
        send_beat(OP_SET, pos, pick_value(25), lo, hi);
      end else if (pick < 93) begin
        pick_range(lo, hi);
        send_beat(OP_QUERY, pos, val, lo, hi);
      end else begin
        send_beat(OP_RSVD, pos, val, lo, hi);
      end
    end

    // Random, second part: no clears, the tree fills up by a sweep of mostly
    // full-scale leaves so that wide sums reach the top bits
    sweep = 1;
    for (int i = 0; i < 1000; i++) begin
      if (i % 100 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      lo   = POS_W'($urandom());
      hi   = POS_W'($urandom());
      if (pick < 80) begin
        if ($urandom_range(0, 99) < 85) begin
          pos   = POS_W'(sweep);
          sweep = (sweep == LEAVES) ? 1 : sweep + 1;
        end else begin
          pos = POS_W'($urandom_range(1, LEAVES));
        end
        send_beat(OP_SET, pos, pick_value(80), lo, hi);
      end else if (pick < 98) begin
        pick_range(lo, hi);
        send_beat(OP_QUERY, POS_W'($urandom()), $urandom(), lo, hi);
      end else begin
        send_beat(OP_RSVD, POS_W'($urandom()), $urandom(), lo, hi);
      end
    end
    s_tvalid <= 1'b0;

    // Drain, then a short settle for stray beats
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(CLK_PERIOD * 3_000_000);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
